### hw/rtl/rslh_pkg.sv
// Package for the ray/light-sphere hit test: widths, configuration and pipeline types.
// Used by every other file of the block; depends on nothing.
`default_nettype none
package rslh_pkg;

   localparam int COORD_W    = 32;
   localparam int DIR_W      = 18;
   localparam int DIST_W     = 31;
   localparam int LUM_W      = 17;
   localparam int COLOR_W    = 24;
   localparam int RF_W       = 31;
   localparam int MIND_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int OC_W    = COORD_W + 1;
   localparam int PROD_W  = OC_W + DIR_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int SQ_W    = 2 * OC_W;
   localparam int CCT_W   = SQ_W - 16;
   localparam int CC_W    = CCT_W + 2;
   localparam int RFL_W   = RF_W + LUM_W;
   localparam int B_W     = DOT_W - 15;
   localparam int C_W     = CC_W + 1;
   localparam int BH_W    = B_W - 16;
   localparam int BB_W    = 62;
   localparam int DISC_W  = 64;
   localparam int ROOT_W  = 38;
   localparam int REM_W   = ROOT_W + 3;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int N_W     = RAD_W - 16;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int V_W     = B_W + 2;

   localparam logic [DIST_W-1:0] T_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X       = 3'd0,
      CSR_LIGHT_Y       = 3'd1,
      CSR_LIGHT_Z       = 3'd2,
      CSR_LIGHT_LUM     = 3'd3,
      CSR_LIGHT_COLOR   = 3'd4,
      CSR_RADIUS_FACTOR = 3'd5,
      CSR_MIN_DISTANCE  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] light_x;
      logic signed [COORD_W-1:0] light_y;
      logic signed [COORD_W-1:0] light_z;
      logic [LUM_W-1:0]          light_lum;
      logic [COLOR_W-1:0]        light_color;
      logic [RF_W-1:0]           radius_factor;
      logic [MIND_W-1:0]         min_distance;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  disc_neg;
      logic signed [B_W-1:0] b;
      logic [DIST_W-1:0]     nearest;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [RAD_W-1:0]    rad;
      logic [REM_W-1:0]    rem;
      logic [ROOT_W-1:0]   root;
   } sqrt_stage_type;

   typedef struct packed {
      logic               hit;
      logic [DIST_W-1:0]  distance;
      logic [COLOR_W-1:0] color;
   } result_type;

endpackage
`default_nettype wire

### hw/rtl/rslh_if.sv
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on rslh_pkg for field widths.
`default_nettype none
interface rslh_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rslh_pkg::COORD_W-1:0] origin_x;
   logic signed [rslh_pkg::COORD_W-1:0] origin_y;
   logic signed [rslh_pkg::COORD_W-1:0] origin_z;
   logic signed [rslh_pkg::DIR_W-1:0]   dir_x;
   logic signed [rslh_pkg::DIR_W-1:0]   dir_y;
   logic signed [rslh_pkg::DIR_W-1:0]   dir_z;
   logic [rslh_pkg::DIST_W-1:0]         nearest_distance;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   nearest_distance, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 nearest_distance, output ready);
endinterface

interface rslh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [rslh_pkg::DIST_W-1:0]  distance;
   logic [rslh_pkg::COLOR_W-1:0] color;

   modport source (output valid, hit, distance, color, input ready);
   modport sink (input valid, hit, distance, color, output ready);
endinterface
`default_nettype wire

### hw/rtl/rslh_front.sv
// Front pipeline: center offset, dot products, squared radius, b, c and discriminant.
// Five register stages; depends on rslh_pkg.
`default_nettype none
module rslh_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic signed [rslh_pkg::COORD_W-1:0] origin_x,
   input  wire logic signed [rslh_pkg::COORD_W-1:0] origin_y,
   input  wire logic signed [rslh_pkg::COORD_W-1:0] origin_z,
   input  wire logic signed [rslh_pkg::DIR_W-1:0]   dir_x,
   input  wire logic signed [rslh_pkg::DIR_W-1:0]   dir_y,
   input  wire logic signed [rslh_pkg::DIR_W-1:0]   dir_z,
   input  wire logic [rslh_pkg::DIST_W-1:0]         nearest,
   input  wire rslh_pkg::cfg_type                   cfg,
   output rslh_pkg::sqrt_stage_type                 stage_out
);

   logic [4:0] valid_ff;

   // stage 1
   logic signed [rslh_pkg::OC_W-1:0]  ocx_ff, ocy_ff, ocz_ff;
   logic signed [rslh_pkg::DIR_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [rslh_pkg::RFL_W-1:0]        rfl_ff;
   logic [rslh_pkg::DIST_W-1:0]       near1_ff;
   // stage 2
   logic signed [rslh_pkg::PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic [rslh_pkg::SQ_W-1:0]          sx_ff, sy_ff, sz_ff;
   logic [rslh_pkg::RF_W-1:0]          r2_ff;
   logic [rslh_pkg::DIST_W-1:0]        near2_ff;
   // stage 3
   logic signed [rslh_pkg::B_W-1:0]    b3_ff;
   logic signed [rslh_pkg::C_W-1:0]    c3_ff;
   logic [rslh_pkg::DIST_W-1:0]        near3_ff;
   // stage 4
   logic [2*rslh_pkg::BH_W-1:0]        hh_ff;
   logic [rslh_pkg::B_W-1:0]           hl_ff;
   logic [31:0]                        ll_ff;
   logic signed [rslh_pkg::B_W-1:0]    b4_ff;
   logic signed [rslh_pkg::C_W-1:0]    c4_ff;
   logic [rslh_pkg::DIST_W-1:0]        near4_ff;
   // stage 5
   logic signed [rslh_pkg::DISC_W-1:0] disc_ff;
   logic signed [rslh_pkg::B_W-1:0]    b5_ff;
   logic [rslh_pkg::DIST_W-1:0]        near5_ff;

   logic [rslh_pkg::OC_W-1:0]          magx, magy, magz;
   logic signed [rslh_pkg::DOT_W-1:0]  dot_in;
   logic [rslh_pkg::CC_W-1:0]          cc_in;
   logic [rslh_pkg::B_W-1:0]           ub;
   logic [rslh_pkg::BB_W-1:0]          bb_in;
   logic signed [rslh_pkg::DISC_W-1:0] c4x;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_comb begin
      magx   = ocx_ff[rslh_pkg::OC_W-1] ? rslh_pkg::OC_W'(-ocx_ff) : ocx_ff;
      magy   = ocy_ff[rslh_pkg::OC_W-1] ? rslh_pkg::OC_W'(-ocy_ff) : ocy_ff;
      magz   = ocz_ff[rslh_pkg::OC_W-1] ? rslh_pkg::OC_W'(-ocz_ff) : ocz_ff;
      dot_in = rslh_pkg::DOT_W'(px_ff) + rslh_pkg::DOT_W'(py_ff) + rslh_pkg::DOT_W'(pz_ff);
      cc_in  = rslh_pkg::CC_W'(sx_ff[rslh_pkg::SQ_W-1:16])
             + rslh_pkg::CC_W'(sy_ff[rslh_pkg::SQ_W-1:16])
             + rslh_pkg::CC_W'(sz_ff[rslh_pkg::SQ_W-1:16]);
      ub     = b3_ff[rslh_pkg::B_W-1] ? rslh_pkg::B_W'(-b3_ff) : b3_ff;
      bb_in  = rslh_pkg::BB_W'({hh_ff, 16'b0}) + rslh_pkg::BB_W'({hl_ff, 1'b0})
             + rslh_pkg::BB_W'(ll_ff[31:16]);
      c4x    = {{(rslh_pkg::DISC_W - rslh_pkg::C_W - 2){c4_ff[rslh_pkg::C_W-1]}},
                c4_ff, 2'b00};
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (en) begin
         ocx_ff   <= {cfg.light_x[31], cfg.light_x} - {origin_x[31], origin_x};
         ocy_ff   <= {cfg.light_y[31], cfg.light_y} - {origin_y[31], origin_y};
         ocz_ff   <= {cfg.light_z[31], cfg.light_z} - {origin_z[31], origin_z};
         dx_ff    <= dir_x;
         dy_ff    <= dir_y;
         dz_ff    <= dir_z;
         rfl_ff   <= rslh_pkg::RFL_W'(cfg.radius_factor) * rslh_pkg::RFL_W'(cfg.light_lum);
         near1_ff <= nearest;

         px_ff    <= ocx_ff * dx_ff;
         py_ff    <= ocy_ff * dy_ff;
         pz_ff    <= ocz_ff * dz_ff;
         sx_ff    <= magx * magx;
         sy_ff    <= magy * magy;
         sz_ff    <= magz * magz;
         r2_ff    <= rfl_ff[rslh_pkg::RFL_W-1:17];
         near2_ff <= near1_ff;

         b3_ff    <= dot_in[rslh_pkg::DOT_W-1:15];
         c3_ff    <= $signed({1'b0, cc_in}) - $signed({{(rslh_pkg::C_W - rslh_pkg::RF_W){1'b0}}, r2_ff});
         near3_ff <= near2_ff;

         hh_ff    <= ub[rslh_pkg::B_W-1:16] * ub[rslh_pkg::B_W-1:16];
         hl_ff    <= ub[rslh_pkg::B_W-1:16] * ub[15:0];
         ll_ff    <= ub[15:0] * ub[15:0];
         b4_ff    <= b3_ff;
         c4_ff    <= c3_ff;
         near4_ff <= near3_ff;

         disc_ff  <= $signed({{(rslh_pkg::DISC_W - rslh_pkg::BB_W){1'b0}}, bb_in}) - c4x;
         b5_ff    <= b4_ff;
         near5_ff <= near4_ff;
      end
   end

   always_comb begin
      stage_out.side.valid    = valid_ff[4];
      stage_out.side.disc_neg = disc_ff[rslh_pkg::DISC_W-1];
      stage_out.side.b        = b5_ff;
      stage_out.side.nearest  = near5_ff;
      stage_out.rad           = {disc_ff[rslh_pkg::N_W-1:0], 16'b0};
      stage_out.rem           = '0;
      stage_out.root          = '0;
   end

endmodule
`default_nettype wire

### hw/rtl/rslh_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit and passes on to the next cell.
// Depends on rslh_pkg.
`default_nettype none
module rslh_sqrt_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire rslh_pkg::sqrt_stage_type stage_in,
   output rslh_pkg::sqrt_stage_type      stage_out
);

   logic                     valid_ff;
   rslh_pkg::side_type       side_ff;
   logic [rslh_pkg::RAD_W-1:0]  rad_ff;
   logic [rslh_pkg::REM_W-1:0]  rem_ff;
   logic [rslh_pkg::ROOT_W-1:0] root_ff;

   logic [rslh_pkg::REM_W-1:0]  rem_sh;
   logic [rslh_pkg::REM_W-1:0]  trial;
   logic [rslh_pkg::REM_W-1:0]  rem_in;
   logic [rslh_pkg::ROOT_W-1:0] root_in;

   always_comb begin
      rem_sh = {stage_in.rem[rslh_pkg::REM_W-3:0],
                stage_in.rad[rslh_pkg::RAD_W-1:rslh_pkg::RAD_W-2]};
      trial  = rslh_pkg::REM_W'({stage_in.root, 2'b01});
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {stage_in.root[rslh_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {stage_in.root[rslh_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= stage_in.side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= stage_in.side;
         rad_ff  <= {stage_in.rad[rslh_pkg::RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   always_comb begin
      stage_out            = {side_ff, rad_ff, rem_ff, root_ff};
      stage_out.side.valid = valid_ff;
   end

endmodule
`default_nettype wire

### hw/rtl/ray_sphere_light_hit.sv
// Top level of the ray against spherical light hit test.
// Depends on rslh_pkg, rslh_if, rslh_front and rslh_sqrt_cell.
//
// Usage:
//  - req_ch carries one ray per transfer: origin (Q16.16), unit direction
//    (signed Q2.16) and the current nearest hit distance (unsigned Q15.16).
//  - rsp_ch returns exactly one result per ray, in order: hit, the new
//    distance (or the input distance on a miss) and the light color (zero
//    on a miss).
//  - csr_* writes the light registers; index 7 is ignored. Write only while
//    no ray is in flight.
//  - A request passes through five front stages (offset, products, sums,
//    b squared partials, discriminant), a chain of 38 square-root cells,
//    one root bit per cell, and the output register that drives rsp valid.
//  - Throughput is one ray per cycle while the skid entry is empty. The whole
//    pipe advances together; an output register plus a one-entry skid let the
//    pipe keep moving when rsp stalls until a result lands in the skid, after
//    which req ready drops until the skid drains.
//  - Reset (synchronous) empties the pipe and loads the register defaults.
`default_nettype none
module ray_sphere_light_hit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rslh_req_if.sink                                req_ch,
   rslh_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [rslh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rslh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rslh_pkg::cfg_type        cfg_ff;
   rslh_pkg::sqrt_stage_type chain [0:rslh_pkg::SQRT_CELLS];

   logic                     en;
   logic                     out_valid_ff;
   rslh_pkg::result_type     out_ff;
   logic                     skid_valid_ff;
   rslh_pkg::result_type     skid_ff;

   rslh_pkg::sqrt_stage_type last;
   logic signed [rslh_pkg::V_W-1:0] v;
   logic [rslh_pkg::B_W-1:0]        t_wide;
   logic [rslh_pkg::DIST_W-1:0]     t_sat;
   logic                            new_valid;
   rslh_pkg::result_type            new_res;
   logic                            pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_x       <= '0;
         cfg_ff.light_y       <= '0;
         cfg_ff.light_z       <= '0;
         cfg_ff.light_lum     <= rslh_pkg::LUM_W'(65536);
         cfg_ff.light_color   <= '1;
         cfg_ff.radius_factor <= rslh_pkg::RF_W'(65536);
         cfg_ff.min_distance  <= rslh_pkg::MIND_W'(1);
      end else if (csr_we) begin
         unique case (rslh_pkg::csr_index_type'(csr_index))
            rslh_pkg::CSR_LIGHT_X:       cfg_ff.light_x <= csr_wdata;
            rslh_pkg::CSR_LIGHT_Y:       cfg_ff.light_y <= csr_wdata;
            rslh_pkg::CSR_LIGHT_Z:       cfg_ff.light_z <= csr_wdata;
            rslh_pkg::CSR_LIGHT_LUM:     cfg_ff.light_lum <= csr_wdata[rslh_pkg::LUM_W-1:0];
            rslh_pkg::CSR_LIGHT_COLOR:   cfg_ff.light_color <= csr_wdata[rslh_pkg::COLOR_W-1:0];
            rslh_pkg::CSR_RADIUS_FACTOR: cfg_ff.radius_factor <= csr_wdata[rslh_pkg::RF_W-1:0];
            rslh_pkg::CSR_MIN_DISTANCE:  cfg_ff.min_distance <= csr_wdata[rslh_pkg::MIND_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the whole pipe only while the skid entry is occupied
   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   rslh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .origin_x  (req_ch.origin_x),
      .origin_y  (req_ch.origin_y),
      .origin_z  (req_ch.origin_z),
      .dir_x     (req_ch.dir_x),
      .dir_y     (req_ch.dir_y),
      .dir_z     (req_ch.dir_z),
      .nearest   (req_ch.nearest_distance),
      .cfg       (cfg_ff),
      .stage_out (chain[0])
   );

   for (genvar g = 0; g < rslh_pkg::SQRT_CELLS; g++) begin : g_cell
      rslh_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // final compare: t = (b - sqrt(disc)) / 2, saturated, then window test
   always_comb begin
      last   = chain[rslh_pkg::SQRT_CELLS];
      v      = rslh_pkg::V_W'(last.side.b) - $signed({2'b00, last.root});
      t_wide = v[rslh_pkg::B_W:1];
      t_sat  = (|t_wide[rslh_pkg::B_W-1:rslh_pkg::DIST_W]) ? rslh_pkg::T_MAX
                                                           : t_wide[rslh_pkg::DIST_W-1:0];
      new_res.hit = !last.side.disc_neg && (v > 0)
                    && (t_sat > rslh_pkg::DIST_W'(cfg_ff.min_distance))
                    && (t_sat < last.side.nearest);
      new_res.distance = new_res.hit ? t_sat : last.side.nearest;
      new_res.color    = new_res.hit ? cfg_ff.light_color : '0;
      new_valid        = en && last.side.valid;
      pop              = out_valid_ff && rsp_ch.ready;
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= new_valid;
         end
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : new_res;
      end else if (new_valid) begin
         skid_ff <= new_res;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.hit      = out_ff.hit;
   assign rsp_ch.distance = out_ff.distance;
   assign rsp_ch.color    = out_ff.color;

   // skid entry only ever sits behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied with empty output register");

   // no request transfer while the pipe is held
   a_no_accept_held: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !(req_ch.valid && req_ch.ready))
      else $error("request transfer while pipe held");

   // a miss never reports a color
   a_miss_no_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.hit) |-> (rsp_ch.color == '0))
      else $error("miss result carries a color");

   // a stalled output with a full skid keeps the skid full
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ch.ready) |=> skid_valid_ff)
      else $error("skid entry lost during stall");

endmodule
`default_nettype wire
